[rtl/assert_macros.svh]
// Assertion shorthands for the descriptor queue RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Whenever pre holds, post must hold in the same cycle.
`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

[rtl/dmq_pkg.sv]
package dmq_pkg;

  // Request codes.
  localparam logic [2:0] OP_RESERVE     = 3'd0;
  localparam logic [2:0] OP_COMMIT      = 3'd1;
  localparam logic [2:0] OP_DISCARD     = 3'd2;
  localparam logic [2:0] OP_COMMIT_EXT  = 3'd3;
  localparam logic [2:0] OP_READ        = 3'd4;
  localparam logic [2:0] OP_ACK         = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_NODE     = 3'd1;
  localparam logic [2:0] ST_NO_MEM      = 3'd2;
  localparam logic [2:0] ST_INVALID     = 3'd3;
  localparam logic [2:0] ST_EMPTY       = 3'd4;

  // Node life cycle.
  localparam logic [1:0] PH_FREE        = 2'd0;
  localparam logic [1:0] PH_RESERVED    = 2'd1;
  localparam logic [1:0] PH_QUEUED      = 2'd2;
  localparam logic [1:0] PH_READ        = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] REG_HEADER_BYTES = 1'b0;
  localparam logic [0:0] REG_DATA_BUDGET  = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  handle;
    logic [31:0] msg_length;
    logic        header_given;
    logic        release_hook;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  out_handle;
    logic [31:0] out_length;
    logic        was_external;
    logic        call_release;
    logic        queue_empty;
    logic [6:0]  queue_length;
    logic [31:0] internal_bytes;
    logic [31:0] external_bytes;
    logic [6:0]  peak_length;
    logic [31:0] peak_internal_bytes;
  } rsp_item_t;

  typedef struct packed {
    logic [31:0] length;
    logic [31:0] reserved_bytes;
    logic        external;
    logic        hook;
    logic [1:0]  phase;
  } node_rec_t;

  typedef struct packed {
    logic [31:0] internal;
    logic [31:0] external;
    logic [31:0] peak_internal;
  } totals_t;

  typedef struct packed {
    logic        add_int;
    logic        sub_int;
    logic        add_ext;
    logic        sub_ext;
    logic [31:0] amount;
  } acct_req_t;

endpackage

[rtl/descriptor_message_queue_top.sv]
// Channel   Handshake                  Payload            Direction
// req       req_valid / req_stall      dmq_pkg::req_item_t  into the block
// rsp       rsp_valid / rsp_stall      dmq_pkg::rsp_item_t  out of the block
// cfg       cfg_we                     cfg_index, cfg_data  into the block
//
// One request transaction can be accepted in every cycle while req_stall is low;
// it is held in the execute stage, then its result goes to the output register.
// The node record and link stores are read with registered reads at the accept
// edge and written back when the request executes, with same-edge forwarding.
// Reset is synchronous: a fill counter marks which nodes were ever handed out, so
// the free chain needs no clearing pass over the stores.
// A held result stalls the request channel only while the result register is full.
`include "assert_macros.svh"

module descriptor_message_queue_top #(
  parameter int NODES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  dmq_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output dmq_pkg::rsp_item_t rsp,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);

  // Next node of the free chain as laid out at reset: i points to i+1 and the
  // last node points back to zero.
  function automatic logic [IDX_W-1:0] chain_link(input logic [IDX_W-1:0] a);
    logic [IDX_W:0] s;
    s = (IDX_W + 1)'(a) + (IDX_W + 1)'(1);
    return (s < (IDX_W + 1)'(NODES)) ? s[IDX_W-1:0] : '0;
  endfunction

  // Configuration registers.
  logic [15:0] header_bytes;
  logic [31:0] data_budget;

  // Per-node stores. Both are plain synchronous RAMs with no reset.
  dmq_pkg::node_rec_t node_mem [NODES];
  logic [IDX_W-1:0]   link_mem [NODES];

  // List state.
  logic [IDX_W-1:0] free_head;
  logic [IDX_W-1:0] queue_head;
  logic [IDX_W-1:0] queue_tail;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] waiting_count;
  logic [CNT_W-1:0] peak_waiting;
  logic [CNT_W-1:0] fill;
  dmq_pkg::totals_t totals;

  // Execute stage: the accepted request plus the data read for it.
  logic               x_valid;
  dmq_pkg::req_item_t x_item;
  logic               x_hok;
  logic [IDX_W-1:0]   x_hi;
  dmq_pkg::node_rec_t rec_rd;
  logic               rec_byp;
  dmq_pkg::node_rec_t rec_bdata;
  logic               rec_fresh;
  logic [IDX_W-1:0]   lf_rd;
  logic [IDX_W-1:0]   lq_rd;
  logic               lf_byp;
  logic               lq_byp;
  logic [IDX_W-1:0]   link_bdata;
  logic               lf_fresh;
  logic               lq_fresh;
  logic [IDX_W-1:0]   lf_addr;
  logic [IDX_W-1:0]   lq_addr;

  // Handshake.
  logic x_fire;
  logic req_accept;

  assign x_fire     = x_valid && (!rsp_valid || !rsp_stall);
  assign req_stall  = x_valid && rsp_valid && rsp_stall;
  assign req_accept = req_valid && !req_stall;

  // Effective read data: a write on the read edge wins, then a node that was
  // never handed out shows its reset contents.
  dmq_pkg::node_rec_t rec_cur;
  logic [IDX_W-1:0]   link_free;
  logic [IDX_W-1:0]   link_queue;

  always_comb begin
    rec_cur = rec_byp ? rec_bdata : rec_rd;
    if (!rec_byp && rec_fresh) begin
      rec_cur.phase = dmq_pkg::PH_FREE;
    end
  end

  assign link_free  = lf_byp ? link_bdata : (lf_fresh ? chain_link(lf_addr) : lf_rd);
  assign link_queue = lq_byp ? link_bdata : (lq_fresh ? chain_link(lq_addr) : lq_rd);

  // Request execution.
  logic [2:0]         st;
  logic [IDX_W-1:0]   oh;
  logic [31:0]        olen;
  logic               oext;
  logic               orel;
  logic [IDX_W-1:0]   free_head_next;
  logic [IDX_W-1:0]   queue_head_next;
  logic [IDX_W-1:0]   queue_tail_next;
  logic [CNT_W-1:0]   free_count_next;
  logic [CNT_W-1:0]   waiting_count_next;
  logic [CNT_W-1:0]   peak_waiting_next;
  logic [CNT_W-1:0]   fill_next;
  logic               rec_we;
  logic [IDX_W-1:0]   rec_wa;
  dmq_pkg::node_rec_t rec_wd;
  logic               link_we;
  logic [IDX_W-1:0]   link_wa;
  logic [IDX_W-1:0]   link_wd;
  logic               take;
  logic               enq;
  logic               rel;
  logic [IDX_W-1:0]   enq_node;
  dmq_pkg::acct_req_t acct;
  logic               fits;
  dmq_pkg::totals_t   totals_next;

  always_comb begin
    st                 = dmq_pkg::ST_OK;
    oh                 = '0;
    olen               = '0;
    oext               = 1'b0;
    orel               = 1'b0;
    free_head_next     = free_head;
    queue_head_next    = queue_head;
    queue_tail_next    = queue_tail;
    free_count_next    = free_count;
    waiting_count_next = waiting_count;
    peak_waiting_next  = peak_waiting;
    fill_next          = fill;
    rec_we             = 1'b0;
    rec_wa             = x_hi;
    rec_wd             = rec_cur;
    link_we            = 1'b0;
    link_wa            = x_hi;
    link_wd            = '0;
    take               = 1'b0;
    enq                = 1'b0;
    rel                = 1'b0;
    enq_node           = x_hi;
    acct               = '0;

    case (x_item.op)
      dmq_pkg::OP_RESERVE: begin
        if (free_count == '0) begin
          st = dmq_pkg::ST_NO_NODE;
        end else if (!fits) begin
          st = dmq_pkg::ST_NO_MEM;
        end else begin
          take                  = 1'b1;
          rec_wa                = free_head;
          rec_wd.length         = x_item.msg_length;
          rec_wd.reserved_bytes = x_item.msg_length;
          rec_wd.external       = 1'b0;
          rec_wd.hook           = 1'b0;
          rec_wd.phase          = dmq_pkg::PH_RESERVED;
          acct.add_int          = 1'b1;
          acct.amount           = x_item.msg_length;
          oh                    = free_head;
        end
      end
      dmq_pkg::OP_COMMIT: begin
        if (!x_hok || (rec_cur.phase != dmq_pkg::PH_RESERVED) ||
            (x_item.msg_length > rec_cur.length)) begin
          st = dmq_pkg::ST_INVALID;
        end else begin
          rec_wd.length = x_item.msg_length;
          rec_wd.hook   = x_item.release_hook;
          enq           = 1'b1;
          enq_node      = x_hi;
        end
      end
      dmq_pkg::OP_DISCARD, dmq_pkg::OP_ACK: begin
        if (!x_hok || (rec_cur.phase != ((x_item.op == dmq_pkg::OP_DISCARD) ?
                                         dmq_pkg::PH_RESERVED : dmq_pkg::PH_READ))) begin
          st = dmq_pkg::ST_INVALID;
        end else begin
          oext = rec_cur.external;
          orel = rec_cur.hook;
          rel  = 1'b1;
        end
      end
      dmq_pkg::OP_COMMIT_EXT: begin
        if (free_count == '0) begin
          st = dmq_pkg::ST_NO_MEM;
        end else if ((header_bytes != 16'd0) && !x_item.header_given) begin
          st = dmq_pkg::ST_INVALID;
        end else begin
          take                  = 1'b1;
          enq                   = 1'b1;
          enq_node              = free_head;
          rec_wa                = free_head;
          rec_wd.length         = x_item.msg_length;
          rec_wd.reserved_bytes = '0;
          rec_wd.external       = 1'b1;
          rec_wd.hook           = x_item.release_hook;
          acct.add_ext          = 1'b1;
          acct.amount           = x_item.msg_length;
          oh                    = free_head;
        end
      end
      dmq_pkg::OP_READ: begin
        if (waiting_count == '0) begin
          st = dmq_pkg::ST_EMPTY;
        end else begin
          rec_we       = 1'b1;
          rec_wa       = queue_head;
          rec_wd.phase = dmq_pkg::PH_READ;
          if (waiting_count > CNT_W'(1)) begin
            queue_head_next = link_queue;
          end else begin
            queue_head_next = '0;
            queue_tail_next = '0;
          end
          waiting_count_next = waiting_count - CNT_W'(1);
          oh   = queue_head;
          olen = rec_cur.length;
          oext = rec_cur.external;
        end
      end
      default: begin
        st = dmq_pkg::ST_INVALID;
      end
    endcase

    // Pop the free chain head. Handing out the lowest never-used node grows fill.
    if (take) begin
      rec_we          = 1'b1;
      free_head_next  = link_free;
      free_count_next = free_count - CNT_W'(1);
      if (CNT_W'(free_head) == fill) begin
        fill_next = fill + CNT_W'(1);
      end
    end

    // Append to the waiting list. The link of a tail is never read, so only
    // the old tail is pointed at the new node.
    if (enq) begin
      rec_we       = 1'b1;
      rec_wd.phase = dmq_pkg::PH_QUEUED;
      if (waiting_count == '0) begin
        queue_head_next = enq_node;
      end else begin
        link_we = 1'b1;
        link_wa = queue_tail;
        link_wd = enq_node;
      end
      queue_tail_next    = enq_node;
      waiting_count_next = waiting_count + CNT_W'(1);
      if (waiting_count_next > peak_waiting) begin
        peak_waiting_next = waiting_count_next;
      end
    end

    // Return a node to the front of the free chain.
    if (rel) begin
      rec_we       = 1'b1;
      rec_wd.phase = dmq_pkg::PH_FREE;
      if (rec_cur.external) begin
        acct.sub_ext = 1'b1;
        acct.amount  = rec_cur.length;
      end else begin
        acct.sub_int = 1'b1;
        acct.amount  = rec_cur.reserved_bytes;
      end
      link_we         = 1'b1;
      link_wa         = x_hi;
      link_wd         = (free_count == '0) ? '0 : free_head;
      free_head_next  = x_hi;
      free_count_next = free_count + CNT_W'(1);
    end
  end

  dmq_acct u_acct (
    .totals      (totals),
    .data_budget (data_budget),
    .msg_length  (x_item.msg_length),
    .req         (acct),
    .fits        (fits),
    .totals_next (totals_next)
  );

  // State as it stands after this edge; the next request reads with it.
  logic [IDX_W-1:0] free_head_upd;
  logic [IDX_W-1:0] queue_head_upd;
  logic [CNT_W-1:0] fill_upd;
  logic             rec_we_eff;
  logic             link_we_eff;
  logic             req_hok;
  logic [IDX_W-1:0] req_hi;
  logic [IDX_W-1:0] rec_ra;

  assign free_head_upd  = x_fire ? free_head_next : free_head;
  assign queue_head_upd = x_fire ? queue_head_next : queue_head;
  assign fill_upd       = x_fire ? fill_next : fill;
  assign rec_we_eff     = x_fire && rec_we;
  assign link_we_eff    = x_fire && link_we;
  assign req_hok        = 32'(req.handle) < 32'(NODES);
  assign req_hi         = req_hok ? IDX_W'(req.handle) : '0;
  assign rec_ra         = (req.op == dmq_pkg::OP_READ) ? queue_head_upd : req_hi;

  // Stores: write when a request executes, read when the next one is taken.
  always_ff @(posedge clk) begin
    if (rec_we_eff) begin
      node_mem[rec_wa] <= rec_wd;
    end
    if (req_accept) begin
      rec_rd <= node_mem[rec_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we_eff) begin
      link_mem[link_wa] <= link_wd;
    end
    if (req_accept) begin
      lf_rd <= link_mem[free_head_upd];
      lq_rd <= link_mem[queue_head_upd];
    end
  end

  // Execute stage payload and forwarding flags.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      x_item     <= req;
      x_hok      <= req_hok;
      x_hi       <= req_hi;
      rec_byp    <= rec_we_eff && (rec_wa == rec_ra);
      rec_bdata  <= rec_wd;
      rec_fresh  <= CNT_W'(rec_ra) >= fill_upd;
      lf_byp     <= link_we_eff && (link_wa == free_head_upd);
      lq_byp     <= link_we_eff && (link_wa == queue_head_upd);
      link_bdata <= link_wd;
      lf_fresh   <= CNT_W'(free_head_upd) >= fill_upd;
      lq_fresh   <= CNT_W'(queue_head_upd) >= fill_upd;
      lf_addr    <= free_head_upd;
      lq_addr    <= queue_head_upd;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid       <= 1'b0;
      free_head     <= '0;
      queue_head    <= '0;
      queue_tail    <= '0;
      free_count    <= CNT_W'(NODES);
      waiting_count <= '0;
      peak_waiting  <= '0;
      fill          <= '0;
      totals        <= '0;
    end else begin
      if (req_accept) begin
        x_valid <= 1'b1;
      end else if (x_fire) begin
        x_valid <= 1'b0;
      end
      if (x_fire) begin
        free_head     <= free_head_next;
        queue_head    <= queue_head_next;
        queue_tail    <= queue_tail_next;
        free_count    <= free_count_next;
        waiting_count <= waiting_count_next;
        peak_waiting  <= peak_waiting_next;
        fill          <= fill_next;
        totals        <= totals_next;
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= 16'd0;
      data_budget  <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        dmq_pkg::REG_HEADER_BYTES: header_bytes <= cfg_data[15:0];
        dmq_pkg::REG_DATA_BUDGET:  data_budget  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (x_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (x_fire) begin
      rsp.status              <= st;
      rsp.out_handle          <= 6'(oh);
      rsp.out_length          <= olen;
      rsp.was_external        <= oext;
      rsp.call_release        <= orel;
      rsp.queue_empty         <= (waiting_count_next == '0);
      rsp.queue_length        <= 7'(waiting_count_next);
      rsp.internal_bytes      <= totals_next.internal;
      rsp.external_bytes      <= totals_next.external;
      rsp.peak_length         <= 7'(peak_waiting_next);
      rsp.peak_internal_bytes <= totals_next.peak_internal;
    end
  end

  // Every node is free, waiting, or held by a client.
  `ASSERT_HOLDS(a_node_count, (32'(free_count) + 32'(waiting_count)) <= 32'(NODES), "node count exceeds pool")
  // Nodes in use all come from the range already handed out.
  `ASSERT_HOLDS(a_fill_cover, (32'(NODES) - 32'(free_count)) <= 32'(fill), "node in use beyond fill mark")
  // Requests are held back only by a result that waits.
  `ASSERT_IMPLIES(a_stall_cause, req_stall, rsp_valid && rsp_stall, "request stalled without held result")
  // An empty read must report an empty queue.
  `ASSERT_IMPLIES(a_empty_flag, rsp_valid && (rsp.status == dmq_pkg::ST_EMPTY), rsp.queue_empty, "empty status with waiting messages")

endmodule

[rtl/dmq_acct.sv]
// Byte accounting: budget check for a reservation and the update of the
// internal and external totals and the internal high-water mark.
module dmq_acct (
  input  dmq_pkg::totals_t   totals,
  input  logic [31:0]        data_budget,
  input  logic [31:0]        msg_length,
  input  dmq_pkg::acct_req_t req,
  output logic               fits,
  output dmq_pkg::totals_t   totals_next
);

  logic budget_left;
  logic [31:0] room;

  assign budget_left = data_budget >= totals.internal;
  assign room = data_budget - totals.internal;

  // With the budget lowered under the total, only an empty message fits.
  assign fits = budget_left ? (msg_length <= room) : (msg_length == 32'd0);

  always_comb begin
    totals_next = totals;
    if (req.add_int) begin
      totals_next.internal = totals.internal + req.amount;
    end else if (req.sub_int) begin
      totals_next.internal = totals.internal - req.amount;
    end
    if (req.add_ext) begin
      totals_next.external = totals.external + req.amount;
    end else if (req.sub_ext) begin
      totals_next.external = totals.external - req.amount;
    end
    if (req.add_int && (totals_next.internal > totals.peak_internal)) begin
      totals_next.peak_internal = totals_next.internal;
    end
  end

endmodule
